@@ hw/rtl/abft_pkg.sv @@
// Shared types, constants and saturation helpers for the ABFT checksum verifier.
package abft_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int POS_W    = 6;
	localparam int SUM_W    = 40;
	localparam int THR_W    = 39;
	localparam int SIZE_W   = 7;
	localparam int ELEM_W   = 32;
	localparam int PADDR_W  = 6;
	localparam int PDATA_W  = 64;

	// register indexes, byte address / 8
	localparam logic [2:0] REG_ROW_THR  = 3'd0;
	localparam logic [2:0] REG_COL_THR  = 3'd1;
	localparam logic [2:0] REG_PAIR_TOL = 3'd2;
	localparam logic [2:0] REG_ROWS     = 3'd3;
	localparam logic [2:0] REG_COLS     = 3'd4;

	// result status codes
	localparam logic [1:0] ST_PASS      = 2'd0;
	localparam logic [1:0] ST_CORRECTED = 2'd1;
	localparam logic [1:0] ST_UNRECOV   = 2'd2;
	localparam logic [1:0] ST_TOO_MANY  = 2'd3;

	localparam logic signed [SUM_W-1:0] SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic [THR_W-1:0] row_thr;
		logic [THR_W-1:0] col_thr;
		logic [THR_W-1:0] pair_tol;
		logic [POS_W-1:0] last_row_idx;
		logic [POS_W-1:0] last_col_idx;
	} cfg_t;

	typedef struct packed {
		logic             last_row;
		logic             last_col;
		logic             first_row;
		logic             final_elem;
		logic [POS_W-1:0] row_idx;
		logic [POS_W-1:0] col_idx;
	} item_ctl_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] correction;
		logic [POS_W-1:0]        fault_col;
		logic [POS_W-1:0]        fault_row;
		logic [1:0]              status;
	} result_t;

	function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1]) begin
			r = v[SUM_W] ? SAT_MIN : SAT_MAX;
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] mag40(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = v[SUM_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

@@ hw/rtl/abft_cfg.sv @@
// APB register file for thresholds and matrix size, with size clamping.
module abft_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abft_pkg::PADDR_W-1:0]  paddr,
	input  logic [abft_pkg::PDATA_W-1:0]  pwdata,
	output logic [abft_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output abft_pkg::cfg_t                cfg
);

	logic [abft_pkg::THR_W-1:0]  row_thr_q, col_thr_q, pair_tol_q;
	logic [abft_pkg::SIZE_W-1:0] rows_q, cols_q;
	logic [2:0]                  idx;
	logic                        wr;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_thr_q  <= '0;
			col_thr_q  <= '0;
			pair_tol_q <= '0;
			rows_q     <= abft_pkg::SIZE_W'(abft_pkg::MAX_ROWS);
			cols_q     <= abft_pkg::SIZE_W'(abft_pkg::MAX_COLS);
		end else if (wr) begin
			unique case (idx)
				abft_pkg::REG_ROW_THR:  row_thr_q  <= pwdata[abft_pkg::THR_W-1:0];
				abft_pkg::REG_COL_THR:  col_thr_q  <= pwdata[abft_pkg::THR_W-1:0];
				abft_pkg::REG_PAIR_TOL: pair_tol_q <= pwdata[abft_pkg::THR_W-1:0];
				abft_pkg::REG_ROWS:     rows_q     <= pwdata[abft_pkg::SIZE_W-1:0];
				abft_pkg::REG_COLS:     cols_q     <= pwdata[abft_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			abft_pkg::REG_ROW_THR:  prdata = abft_pkg::PDATA_W'(row_thr_q);
			abft_pkg::REG_COL_THR:  prdata = abft_pkg::PDATA_W'(col_thr_q);
			abft_pkg::REG_PAIR_TOL: prdata = abft_pkg::PDATA_W'(pair_tol_q);
			abft_pkg::REG_ROWS:     prdata = abft_pkg::PDATA_W'(rows_q);
			abft_pkg::REG_COLS:     prdata = abft_pkg::PDATA_W'(cols_q);
			default:                prdata = '0;
		endcase
	end

	// clamp to [2, MAX] and hand out the last index
	always_comb begin
		cfg.row_thr  = row_thr_q;
		cfg.col_thr  = col_thr_q;
		cfg.pair_tol = pair_tol_q;
		if (rows_q < abft_pkg::SIZE_W'(2)) begin
			cfg.last_row_idx = abft_pkg::POS_W'(1);
		end else if (rows_q > abft_pkg::SIZE_W'(abft_pkg::MAX_ROWS)) begin
			cfg.last_row_idx = abft_pkg::POS_W'(abft_pkg::MAX_ROWS - 1);
		end else begin
			cfg.last_row_idx = abft_pkg::POS_W'(rows_q - 1'b1);
		end
		if (cols_q < abft_pkg::SIZE_W'(2)) begin
			cfg.last_col_idx = abft_pkg::POS_W'(1);
		end else if (cols_q > abft_pkg::SIZE_W'(abft_pkg::MAX_COLS)) begin
			cfg.last_col_idx = abft_pkg::POS_W'(abft_pkg::MAX_COLS - 1);
		end else begin
			cfg.last_col_idx = abft_pkg::POS_W'(cols_q - 1'b1);
		end
	end

endmodule

@@ hw/rtl/abft_seq.sv @@
// Row/column position tracker: classifies each incoming element.
module abft_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abft_pkg::cfg_t        cfg,
	input  logic                  accept,
	output abft_pkg::item_ctl_t   ctl
);

	logic [abft_pkg::POS_W-1:0] row_pos_q, col_pos_q;

	always_comb begin
		ctl.last_row   = row_pos_q >= cfg.last_row_idx;
		ctl.last_col   = col_pos_q >= cfg.last_col_idx;
		ctl.first_row  = row_pos_q == '0;
		ctl.final_elem = ctl.last_row & ctl.last_col;
		ctl.row_idx    = row_pos_q;
		ctl.col_idx    = col_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (accept) begin
			if (!ctl.last_col) begin
				col_pos_q <= col_pos_q + 1'b1;
			end else begin
				col_pos_q <= '0;
				row_pos_q <= ctl.last_row ? '0 : row_pos_q + 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/abft_check.sv @@
// Column-sum memory read-modify-write, row accumulator, fault tracking, decision.
module abft_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  abft_pkg::cfg_t                    cfg,
	input  logic                              accept,
	input  abft_pkg::item_ctl_t               ctl,
	input  logic signed [abft_pkg::ELEM_W-1:0] elem,
	input  logic                              out_busy,
	output logic                              stall,
	output logic                              res_valid,
	output abft_pkg::result_t                 res
);

	localparam int W = abft_pkg::SUM_W;

	logic signed [W-1:0] col_mem [abft_pkg::MAX_COLS];

	logic                               valid_s1;
	abft_pkg::item_ctl_t                ctl_s1;
	logic signed [abft_pkg::ELEM_W-1:0] elem_s1;
	logic signed [W-1:0]                rd_s1;

	logic signed [W-1:0] acc_q;
	logic [1:0]          row_cnt_q, col_cnt_q;
	logic [abft_pkg::POS_W-1:0] row_idx_q, col_idx_q;
	logic signed [W-1:0] row_diff_q, col_diff_q;

	logic signed [W:0]   e41;
	logic signed [W-1:0] acc_new, row_d, col_d, col_wdata;
	logic                wr_en, fwd, step;
	logic                row_bad, col_bad;
	logic signed [W:0]   pair_d;
	logic [W:0]          pair_mag;

	assign stall = valid_s1 & ctl_s1.final_elem & out_busy;
	assign step  = valid_s1 & ~stall;

	assign e41       = {{(W + 1 - abft_pkg::ELEM_W){elem_s1[abft_pkg::ELEM_W-1]}}, elem_s1};
	assign acc_new   = abft_pkg::sat40({acc_q[W-1], acc_q} + e41);
	assign row_d     = abft_pkg::sat40({acc_q[W-1], acc_q} - e41);
	assign col_d     = abft_pkg::sat40({rd_s1[W-1], rd_s1} - e41);
	assign col_wdata = ctl_s1.first_row ? e41[W-1:0]
	                                    : abft_pkg::sat40({rd_s1[W-1], rd_s1} + e41);
	assign row_bad   = abft_pkg::mag40(row_d) > {1'b0, cfg.row_thr};
	assign col_bad   = abft_pkg::mag40(col_d) > {1'b0, cfg.col_thr};

	assign wr_en = valid_s1 & ~ctl_s1.last_row & ~ctl_s1.last_col;
	// same column written by the item ahead: take the fresh sum
	assign fwd   = wr_en & (ctl_s1.col_idx == ctl.col_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			col_mem[ctl_s1.col_idx] <= col_wdata;
		end
		if (accept) begin
			rd_s1   <= fwd ? col_wdata : col_mem[ctl.col_idx];
			ctl_s1  <= ctl;
			elem_s1 <= elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			row_cnt_q  <= '0;
			col_cnt_q  <= '0;
			row_idx_q  <= '0;
			col_idx_q  <= '0;
			row_diff_q <= '0;
			col_diff_q <= '0;
		end else if (step) begin
			if (ctl_s1.final_elem) begin
				acc_q      <= '0;
				row_cnt_q  <= '0;
				col_cnt_q  <= '0;
				row_idx_q  <= '0;
				col_idx_q  <= '0;
				row_diff_q <= '0;
				col_diff_q <= '0;
			end else if (!ctl_s1.last_row) begin
				if (!ctl_s1.last_col) begin
					acc_q <= acc_new;
				end else begin
					acc_q <= '0;
					if (row_bad) begin
						if (row_cnt_q != 2'd3) row_cnt_q <= row_cnt_q + 1'b1;
						row_idx_q  <= ctl_s1.row_idx;
						row_diff_q <= row_d;
					end
				end
			end else if (col_bad) begin
				if (col_cnt_q != 2'd3) col_cnt_q <= col_cnt_q + 1'b1;
				col_idx_q  <= ctl_s1.col_idx;
				col_diff_q <= col_d;
			end
		end
	end

	// final decision; the corner element itself is never checked
	assign pair_d   = {row_diff_q[W-1], row_diff_q} - {col_diff_q[W-1], col_diff_q};
	assign pair_mag = pair_d[W] ? (~pair_d + 1'b1) : pair_d;

	always_comb begin
		res.fault_row  = row_idx_q;
		res.fault_col  = col_idx_q;
		res.correction = '0;
		if (row_cnt_q == 2'd1 && col_cnt_q == 2'd1) begin
			if (pair_mag > {2'b00, cfg.pair_tol}) begin
				res.status = abft_pkg::ST_UNRECOV;
			end else begin
				res.status     = abft_pkg::ST_CORRECTED;
				res.correction = (row_diff_q == abft_pkg::SAT_MIN) ? abft_pkg::SAT_MAX
				                                                   : -row_diff_q;
			end
		end else if (row_cnt_q == 2'd0 && col_cnt_q == 2'd0) begin
			res.status = abft_pkg::ST_PASS;
		end else begin
			res.status = abft_pkg::ST_TOO_MANY;
		end
	end

	assign res_valid = step & ctl_s1.final_elem;

endmodule

@@ hw/rtl/abft_checksum_matrix_verify.sv @@
// Top level of the ABFT full-checksum matrix verifier.
//
// Usage:
//  - s_* stream: one signed Q16.16 matrix element per request, row-major. The
//    last column carries row checksums, the last row carries column checksums.
//  - m_* stream: one verdict request after the bottom-right element of each matrix.
//  - APB port: thresholds and matrix size (registers at 8-byte steps); write
//    only while no matrix result is outstanding.
// Throughput: one element per cycle while not stalled. Each element costs one
//   read of the column-sum memory, and each data element (not a checksum) one
//   write; the read issues as the element is taken and the write lands in the
//   next cycle, with a bypass for back-to-back columns. The final element passes
//   through the memory read stage, whose verdict then loads the output register
//   that drives m_tvalid; a full output register can hold it in that stage.
// Stall: the output register holds one verdict; elements keep flowing while it
//   waits. Only a second final element arriving before the first verdict is
//   taken holds s_tready low.
// Reset: registers return to defaults (thresholds 0, 64x64 matrix), positions
//   and fault trackers clear; the column-sum memory needs no clearing because
//   the first data row writes its sums fresh.
module abft_checksum_matrix_verify (
	input  logic        clk,
	input  logic        arst_n,
	// element in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] element
	// verdict out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [1:0] status, [7:2] fault_row, [13:8] fault_col,
	                               // [53:14] correction, [55:54] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	abft_pkg::cfg_t      cfg;
	abft_pkg::item_ctl_t ctl;
	abft_pkg::result_t   res;
	logic                accept, stall, res_valid;
	logic                out_valid_q;
	abft_pkg::result_t   out_q;

	assign s_tready = ~stall;
	assign accept   = s_tvalid & s_tready;

	abft_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// position tracking happens as the element is taken
	abft_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.ctl    (ctl)
	);

	// memory stage: column sums, row sums, fault record, verdict
	abft_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.ctl       (ctl),
		.elem      (s_tdata),
		.out_busy  (out_valid_q & ~m_tready),
		.stall     (stall),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register: loads when free or being drained this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

endmodule
